>>> src/mbpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpf_pkg
// Shared constants for the masked byte pattern finder: register indexes,
// reset values and default sizes.
// ----------------------------------------------------------------------------
package mbpf_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_MASK   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 2'd3;

    // Register field widths and reset values
    localparam int MASK_W = 16;
    localparam int LEN_W  = 5;
    localparam logic [MASK_W-1:0] MASK_RESET   = 16'h0387;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 5'd10;

    // Stream word widths
    localparam int BYTE_W   = 8;
    localparam int RESULT_W = 32;

endpackage

>>> src/masked_byte_pattern_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_finder_top
// Masked byte signature scanner: finds the first window of a byte stream that
// matches a configured pattern and reports the offset of its first wildcard.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one stream byte per word in s_tdata, s_tlast marks the final
//   byte of a stream. m_axis: at most one word per stream; m_tuser is the
//   found flag, m_tdata the stream offset of the first wildcard byte of the
//   matching window (zero when the stream ended without a match).
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (pattern
//   low, pattern high, compare mask, pattern length); write only while idle.
//   Timing: a byte is registered into the window on acceptance, compared in
//   the next cycle, and its result word is then registered in the output
//   register. One byte is accepted every cycle unless the output stalls;
//   the rate is set by the single window compare stage, which runs once per byte.
//   Stalls: when m_tready is low with a word pending, the compare stage
//   holds and s_tready drops once it is occupied; nothing is lost.
//   Reset: the window, byte counter and match flag clear, the registers
//   return to pattern zero, mask 0x0387, length 10, and both channels empty.
// ----------------------------------------------------------------------------
module masked_byte_pattern_finder_top
    import mbpf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RESULT_W-1:0]   m_tdata,   // [31:0] wildcard_offset
    output logic                  m_tuser    // [0] found
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // Configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg, pat_high_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [LEN_W-1:0]      len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            mask_reg     <= MASK_RESET;
            len_reg      <= LENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                REG_COMPARE_MASK:   mask_reg     <= cfg_wdata[MASK_W-1:0];
                REG_PATTERN_LENGTH: len_reg      <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stream state and compare stage registers
    logic [BYTE_W-1:0]      window_reg [MAX_PATTERN];
    logic [BYTE_W-1:0]      window_next [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   done_reg, done_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_last_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg;
    logic [RESULT_W-1:0]    out_off_reg;

    logic s1_adv, accept, clr;

    // compare stage moves when the output register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign clr      = s1_adv && s1_last_reg;

    // Window shift and byte count; a finished stream starts over from zero
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            window_next[j] = clr ? '0 : window_reg[j];
        end
        count_next = clr ? '0 : count_reg;
        if (accept) begin
            for (int j = MAX_PATTERN - 1; j > 0; j--) begin
                window_next[j] = window_next[j-1];
            end
            window_next[0] = s_tdata;
            if (count_next != COUNT_MAX) begin
                count_next = count_next + OFFSET_BITS'(1);
            end
        end
    end

    // Window compare for the word held in the compare stage
    logic [LEN_W-1:0]       len_use;
    logic [2*CFG_DATA_W-1:0] pat_all;
    logic                   mismatch, has_wild, hit;
    logic [LEN_W-1:0]       wild_idx;
    logic [OFFSET_BITS-1:0] hit_off;

    assign len_use = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
    assign pat_all = {pat_high_reg, pat_low_reg};

    always_comb begin
        logic [LEN_W-1:0]  pos;
        logic [BYTE_W-1:0] sb;
        mismatch = 1'b0;
        has_wild = 1'b0;
        wild_idx = '0;
        for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
            pos = len_use - LEN_W'(k) - LEN_W'(1);
            sb  = window_reg[pos[IDX_W-1:0]];
            if (LEN_W'(k) < len_use) begin
                if (mask_reg[k]) begin
                    if (sb != pat_all[k*BYTE_W +: BYTE_W]) begin
                        mismatch = 1'b1;
                    end
                end else begin
                    // scanning downward leaves the lowest wildcard
                    has_wild = 1'b1;
                    wild_idx = LEN_W'(k);
                end
            end
        end
    end

    assign hit = !done_reg && (len_use != '0)
                 && (count_reg >= OFFSET_BITS'(len_use))
                 && !mismatch && has_wild;
    // wildcard index is below the length, so no wrap and no saturation
    assign hit_off = count_reg - OFFSET_BITS'(len_use) + OFFSET_BITS'(wild_idx);

    // Match flag and next control state
    always_comb begin
        done_next      = done_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (s1_adv) begin
            done_next      = s1_last_reg ? 1'b0 : (done_reg || hit);
            out_valid_next = hit || (s1_last_reg && !done_reg);
            s1_valid_next  = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                window_reg[j] <= '0;
            end
            count_reg     <= '0;
            done_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            window_reg    <= window_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg <= s_tlast;
        end
        if (s1_adv) begin
            out_found_reg <= hit;
            if (hit) begin
                // low bits of the offset, zero extended when the counter is narrow
                out_off_reg <= RESULT_W'(hit_off);
            end else begin
                out_off_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_off_reg;
    assign m_tuser  = out_found_reg;

endmodule
